[rtl/assert_macros.svh]
// Assertion macros for the checker module.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every clock edge, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/ktlv_pkg.sv]
// Package for the keyed table with LRU victim choice: widths, command codes,
// and the request, result and controller-to-datapath command structs. No dependencies.
`default_nettype none
package ktlv_pkg;
    localparam int DEPTH   = 32;
    localparam int IDX_W   = 5;
    localparam int CNT_W   = 6;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_TOUCH  = 3'd2;
    localparam logic [2:0] CMD_PRUNE  = 3'd3;
    localparam logic [2:0] CMD_SETACT = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [23:0] key;
        logic [15:0] model_code;
        logic [63:0] callsign;
        logic [7:0]  country_code;
        logic [15:0] distance;
        logic [12:0] bearing;
        logic [31:0] now_ms;
        logic        active_value;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [15:0] model_out;
        logic [4:0]  slot;
        logic [15:0] seen_out;
        logic [5:0]  pruned;
    } rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic             load;     // capture request, clear scan state
        logic             scan;     // examine entry scan_idx
        logic [IDX_W-1:0] scan_idx;
        logic             commit;   // apply the command and build the result
    } dp_cmd_t;
endpackage
`default_nettype wire

[rtl/ktlv_ctrl.sv]
// Controller state machine for the keyed table: sequences the scan and the
// result handshake. Depends on ktlv_pkg.
`default_nettype none
module ktlv_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ktlv_pkg::dp_cmd_t       cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [ktlv_pkg::IDX_W-1:0] idx_reg, idx_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        cmd.load = 1'b0;
        cmd.scan = 1'b0;
        cmd.scan_idx = idx_reg;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == ktlv_pkg::IDX_W'(ktlv_pkg::DEPTH - 1)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end
endmodule
`default_nettype wire

[rtl/ktlv_dp.sv]
// Datapath for the keyed table: entry storage, the per-entry scan for hit,
// empty slot, oldest inactive victim and prune, and the result register.
// Depends on ktlv_pkg.
`default_nettype none
module ktlv_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ktlv_pkg::dp_cmd_t cmd,
    input  wire ktlv_pkg::req_t    req_in,
    input  wire logic [31:0]       cfg_wdata,
    input  wire logic              cfg_wen,
    output ktlv_pkg::rsp_t         rsp
);
    localparam int D = ktlv_pkg::DEPTH;
    localparam int W = ktlv_pkg::IDX_W;

    // Valid and active marks reset with the table; the payload has no reset and
    // is guarded by the valid bit (all fields are written on allocation).
    logic [D-1:0] valid_reg, active_reg;
    logic [23:0] key_reg [D];
    logic [15:0] model_reg [D];
    logic [63:0] call_reg [D];
    logic [7:0]  cntry_reg [D];
    logic [15:0] dist_reg [D];
    logic [12:0] brg_reg [D];
    logic [31:0] last_reg [D];
    logic [15:0] seen_reg [D];
    logic [W-1:0] ring_reg;
    logic [31:0] max_age_reg;

    ktlv_pkg::req_t req_reg;
    logic         hit_reg, empty_reg, vict_reg;
    logic [W-1:0] hit_idx_reg, empty_idx_reg, vict_idx_reg;
    logic [31:0]  best_reg;
    logic [D-1:0] prune_mask_reg;
    logic [ktlv_pkg::CNT_W-1:0] pcnt_reg;
    ktlv_pkg::rsp_t rsp_reg;
    ktlv_pkg::rsp_t rsp_next;

    // Single-entry examination, one entry per scan cycle.
    logic [W-1:0] si;
    logic [31:0]  age;
    logic         e_valid, e_match, e_stale;
    assign si = cmd.scan_idx;
    assign e_valid = valid_reg[si];
    assign age = req_reg.now_ms - last_reg[si];
    assign e_match = e_valid && (key_reg[si] == req_reg.key);
    assign e_stale = e_valid && (last_reg[si] != 32'd0) && (age > max_age_reg);

    logic [W-1:0] tgt;
    logic         is_add, is_hitcmd;
    assign is_add = (req_reg.cmd == ktlv_pkg::CMD_ADD);
    assign is_hitcmd = (req_reg.cmd == ktlv_pkg::CMD_LOOKUP) ||
                       (req_reg.cmd == ktlv_pkg::CMD_TOUCH) ||
                       (req_reg.cmd == ktlv_pkg::CMD_SETACT);
    always_comb begin
        if (hit_reg)        tgt = hit_idx_reg;
        else if (empty_reg) tgt = empty_idx_reg;
        else if (vict_reg)  tgt = vict_idx_reg;
        else                tgt = ring_reg;
    end

    logic [15:0] seen_inc;
    assign seen_inc = (seen_reg[tgt] == 16'hFFFF) ? 16'hFFFF : seen_reg[tgt] + 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            active_reg <= '0;
            ring_reg <= '0;
            max_age_reg <= 32'd60000;
        end else begin
            if (cfg_wen) max_age_reg <= cfg_wdata;
            if (cmd.commit) begin
                if (is_add) begin
                    if (!hit_reg) begin
                        valid_reg[tgt] <= 1'b1;
                        active_reg[tgt] <= 1'b0;
                        if (!empty_reg) ring_reg <= ring_reg + 1'b1;
                    end
                end else if (req_reg.cmd == ktlv_pkg::CMD_SETACT) begin
                    if (hit_reg) active_reg[tgt] <= req_reg.active_value;
                end else if (req_reg.cmd == ktlv_pkg::CMD_PRUNE) begin
                    valid_reg <= valid_reg & ~prune_mask_reg;
                    active_reg <= active_reg & ~prune_mask_reg;
                end
            end
        end
    end

    // Entry payload; a pruned entry is cleared one slot per scan cycle.
    always_ff @(posedge aclk) begin
        if (cmd.scan && req_reg.cmd == ktlv_pkg::CMD_PRUNE && e_stale) begin
            key_reg[si] <= '0;
            model_reg[si] <= '0;
            call_reg[si] <= '0;
            cntry_reg[si] <= '0;
            dist_reg[si] <= '0;
            brg_reg[si] <= '0;
            last_reg[si] <= '0;
            seen_reg[si] <= '0;
        end
        if (cmd.commit) begin
            if (is_add && hit_reg) begin
                if (req_reg.model_code != 16'd0) model_reg[tgt] <= req_reg.model_code;
                if (req_reg.callsign != 64'd0) call_reg[tgt] <= req_reg.callsign;
                if (req_reg.country_code != 8'd0) cntry_reg[tgt] <= req_reg.country_code;
                if (!req_reg.distance[15]) dist_reg[tgt] <= req_reg.distance;
                if (!req_reg.bearing[12]) brg_reg[tgt] <= req_reg.bearing;
                last_reg[tgt] <= req_reg.now_ms;
                seen_reg[tgt] <= seen_inc;
            end else if (is_add) begin
                key_reg[tgt] <= req_reg.key;
                model_reg[tgt] <= req_reg.model_code;
                call_reg[tgt] <= req_reg.callsign;
                cntry_reg[tgt] <= req_reg.country_code;
                dist_reg[tgt] <= req_reg.distance;
                brg_reg[tgt] <= req_reg.bearing;
                last_reg[tgt] <= req_reg.now_ms;
                seen_reg[tgt] <= 16'd1;
            end else if (req_reg.cmd == ktlv_pkg::CMD_TOUCH && hit_reg) begin
                last_reg[tgt] <= req_reg.now_ms;
                seen_reg[tgt] <= seen_inc;
            end
        end
    end

    // Scan bookkeeping.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req_in;
            hit_reg <= 1'b0;
            empty_reg <= 1'b0;
            vict_reg <= 1'b0;
            hit_idx_reg <= '0;
            empty_idx_reg <= '0;
            vict_idx_reg <= '0;
            best_reg <= '0;
            prune_mask_reg <= '0;
            pcnt_reg <= '0;
        end else if (cmd.scan) begin
            if (e_match && !hit_reg) begin
                hit_reg <= 1'b1;
                hit_idx_reg <= si;
            end
            if (!e_valid && !empty_reg) begin
                empty_reg <= 1'b1;
                empty_idx_reg <= si;
            end
            if (!active_reg[si] && (!vict_reg || age > best_reg)) begin
                vict_reg <= 1'b1;
                vict_idx_reg <= si;
                best_reg <= age;
            end
            if (req_reg.cmd == ktlv_pkg::CMD_PRUNE && e_stale) begin
                prune_mask_reg[si] <= 1'b1;
                pcnt_reg <= pcnt_reg + 1'b1;
            end
        end
    end

    // Result, built from the values the entry will hold after commit.
    always_comb begin
        rsp_next = '0;
        if (is_add) begin
            rsp_next.found = hit_reg;
            rsp_next.slot = tgt;
            if (hit_reg) begin
                rsp_next.model_out = (req_reg.model_code != 16'd0) ?
                                     req_reg.model_code : model_reg[tgt];
                rsp_next.seen_out = seen_inc;
            end else begin
                rsp_next.model_out = req_reg.model_code;
                rsp_next.seen_out = 16'd1;
            end
        end else if (is_hitcmd && hit_reg) begin
            rsp_next.found = 1'b1;
            rsp_next.slot = tgt;
            rsp_next.model_out = model_reg[tgt];
            rsp_next.seen_out = (req_reg.cmd == ktlv_pkg::CMD_TOUCH) ?
                                seen_inc : seen_reg[tgt];
        end else if (req_reg.cmd == ktlv_pkg::CMD_PRUNE) begin
            rsp_next.pruned = pcnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;
endmodule
`default_nettype wire

[rtl/keyed_table_lru_victim.sv]
// Top level of the keyed table with LRU victim choice: joins the controller
// and the datapath. Depends on ktlv_pkg, ktlv_ctrl and ktlv_dp.
//
//   channel   direction  handshake          payload
//   s_axis    in         s_tvalid/s_tready  s_tdata (request fields)
//   m_axis    out        m_tvalid/m_tready  m_tdata (result fields)
//   cfg       in         cfg_wen            cfg_wdata (max_age_ms)
//
// A request is accepted in an idle cycle; the shared compare unit then
// examines one entry per scan cycle in index order, and a commit cycle builds
// the result in its register. The table depth sets the length of the scan.
// With m_tready high the result leaves as soon as it is valid, and the block
// then returns to idle. The result waits in its register until m_tready; no
// new request is taken until it leaves. Reset (synchronous, active low)
// empties the table at once and sets max_age_ms to 60000.
`default_nettype none
module keyed_table_lru_victim (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata from bit 0: cmd(3), key(24), model_code(16), callsign(64),
    // country_code(8), distance(16), bearing(13), now_ms(32), active_value(1),
    // then seven zero bits.
    input  wire logic [183:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata from bit 0: found(1), model_out(16), slot(5), seen_out(16),
    // pruned(6), then four zero bits.
    output logic [47:0]       m_tdata,
    input  wire logic         cfg_wen,
    input  wire logic [31:0]  cfg_wdata
);
    ktlv_pkg::dp_cmd_t cmd;
    ktlv_pkg::req_t    req;
    ktlv_pkg::rsp_t    rsp;

    // Unpack the request fields, first field in the lowest bits.
    assign req.cmd          = s_tdata[2:0];
    assign req.key          = s_tdata[26:3];
    assign req.model_code   = s_tdata[42:27];
    assign req.callsign     = s_tdata[106:43];
    assign req.country_code = s_tdata[114:107];
    assign req.distance     = s_tdata[130:115];
    assign req.bearing      = s_tdata[143:131];
    assign req.now_ms       = s_tdata[175:144];
    assign req.active_value = s_tdata[176];

    ktlv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    ktlv_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .req_in    (req),
        .cfg_wdata (cfg_wdata),
        .cfg_wen   (cfg_wen),
        .rsp       (rsp)
    );

    assign m_tdata = {4'd0, rsp.pruned, rsp.seen_out, rsp.slot, rsp.model_out, rsp.found};
endmodule
`default_nettype wire

[rtl/ktlv_checker.sv]
// Port-level checker for keyed_table_lru_victim, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ktlv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);
    `ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "ready while result pending")
    `ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready, !s_tready && !m_tvalid, "request not held")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `ASSERT_IMPL(a_pruned_only, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[43:38] == 6'd0, "found with pruned")
endmodule

bind keyed_table_lru_victim ktlv_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

[tb/tb_top.sv]
// Testbench for keyed_table_lru_victim: random and directed requests, an own table predictor.
// Depends on ktlv_pkg and the keyed_table_lru_victim RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Table predictor and the queue of expected results.
    class table_scoreboard;
        bit        valid [ktlv_pkg::DEPTH];
        bit [23:0] key_q [ktlv_pkg::DEPTH];
        bit [15:0] model [ktlv_pkg::DEPTH];
        bit [63:0] call [ktlv_pkg::DEPTH];
        bit [7:0]  country [ktlv_pkg::DEPTH];
        bit [15:0] dist_q [ktlv_pkg::DEPTH];
        bit [12:0] brg [ktlv_pkg::DEPTH];
        bit        act [ktlv_pkg::DEPTH];
        bit [31:0] seen_at [ktlv_pkg::DEPTH];
        bit [15:0] seen_cnt [ktlv_pkg::DEPTH];
        bit [ktlv_pkg::IDX_W-1:0] ring;
        bit [31:0] max_age;
        ktlv_pkg::rsp_t pending[$];
        int        errors;
        int        checked;

        function new();
            for (int i = 0; i < ktlv_pkg::DEPTH; i++) wipe(i);
            ring = '0;
            max_age = 32'd60000;
            errors = 0;
            checked = 0;
        endfunction

        function void wipe(int i);
            valid[i] = 0; key_q[i] = 0; model[i] = 0; call[i] = 0; country[i] = 0;
            dist_q[i] = 0; brg[i] = 0; act[i] = 0; seen_at[i] = 0; seen_cnt[i] = 0;
        endfunction

        function int find(bit [23:0] k);
            for (int i = 0; i < ktlv_pkg::DEPTH; i++)
                if (valid[i] && key_q[i] == k) return i;
            return -1;
        endfunction

        // Notes an accepted request and queues the result it must cause.
        function void note_request(ktlv_pkg::req_t r);
            ktlv_pkg::rsp_t e;
            int idx;
            int cnt;
            bit [31:0] best;
            bit [31:0] age;
            e = '0;
            idx = -1;
            cnt = 0;
            case (r.cmd)
                ktlv_pkg::CMD_ADD: begin
                    idx = find(r.key);
                    if (idx >= 0) begin
                        // A hit only ever adds information, never removes it.
                        e.found = 1;
                        if (r.model_code != 0) model[idx] = r.model_code;
                        if (r.callsign != 0) call[idx] = r.callsign;
                        if (r.country_code != 0) country[idx] = r.country_code;
                        if (!r.distance[15]) dist_q[idx] = r.distance;
                        if (!r.bearing[12]) brg[idx] = r.bearing;
                        seen_at[idx] = r.now_ms;
                        if (seen_cnt[idx] != 16'hFFFF) seen_cnt[idx]++;
                    end else begin
                        for (int i = 0; i < ktlv_pkg::DEPTH; i++)
                            if (!valid[i]) begin
                                idx = i;
                                break;
                            end
                        if (idx < 0) begin
                            best = 0;
                            for (int i = 0; i < ktlv_pkg::DEPTH; i++) begin
                                if (act[i]) continue;
                                age = r.now_ms - seen_at[i];
                                if (idx < 0 || age > best) begin
                                    best = age;
                                    idx = i;
                                end
                            end
                            if (idx < 0) idx = ring;
                            ring++;
                        end
                        valid[idx] = 1; key_q[idx] = r.key; model[idx] = r.model_code;
                        call[idx] = r.callsign; country[idx] = r.country_code;
                        dist_q[idx] = r.distance; brg[idx] = r.bearing; act[idx] = 0;
                        seen_at[idx] = r.now_ms; seen_cnt[idx] = 1;
                    end
                end
                ktlv_pkg::CMD_LOOKUP, ktlv_pkg::CMD_TOUCH, ktlv_pkg::CMD_SETACT: begin
                    idx = find(r.key);
                    if (idx >= 0) begin
                        e.found = 1;
                        if (r.cmd == ktlv_pkg::CMD_TOUCH) begin
                            seen_at[idx] = r.now_ms;
                            if (seen_cnt[idx] != 16'hFFFF) seen_cnt[idx]++;
                        end else if (r.cmd == ktlv_pkg::CMD_SETACT) begin
                            act[idx] = r.active_value;
                        end
                    end
                end
                ktlv_pkg::CMD_PRUNE: begin
                    for (int i = 0; i < ktlv_pkg::DEPTH; i++) begin
                        if (!valid[i] || seen_at[i] == 0) continue;
                        if (r.now_ms - seen_at[i] > max_age) begin
                            wipe(i);
                            cnt++;
                        end
                    end
                end
                default: ;
            endcase
            if (idx >= 0) begin
                e.model_out = model[idx];
                e.slot = idx[ktlv_pkg::IDX_W-1:0];
                e.seen_out = seen_cnt[idx];
            end
            e.pruned = cnt[ktlv_pkg::CNT_W-1:0];
            pending.push_back(e);
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(ktlv_pkg::rsp_t got);
            ktlv_pkg::rsp_t e;
            checked++;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.found !== e.found) begin
                $error("found: expected %0d, got %0d", e.found, got.found);
                errors++;
            end
            if (got.model_out !== e.model_out) begin
                $error("model_out: expected %0d, got %0d", e.model_out, got.model_out);
                errors++;
            end
            if (got.slot !== e.slot) begin
                $error("slot: expected %0d, got %0d", e.slot, got.slot);
                errors++;
            end
            if (got.seen_out !== e.seen_out) begin
                $error("seen_out: expected %0d, got %0d", e.seen_out, got.seen_out);
                errors++;
            end
            if (got.pruned !== e.pruned) begin
                $error("pruned: expected %0d, got %0d", e.pruned, got.pruned);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 1_000_000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [183:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         cfg_wen;
    logic [31:0]  cfg_wdata;

    table_scoreboard sb;
    int        cycles;
    int        sent;
    bit [23:0] keys [16];   // small key pool so hits are common
    bit [31:0] clock_ms;    // advancing request time stamp

    keyed_table_lru_victim dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Packs a request with cmd in the lowest bits, then seven zero bits on top.
    function automatic logic [183:0] pack_request(ktlv_pkg::req_t r);
        return {7'b0, r.active_value, r.now_ms, r.bearing, r.distance, r.country_code,
                r.callsign, r.model_code, r.key, r.cmd};
    endfunction

    function automatic ktlv_pkg::rsp_t unpack_result(logic [47:0] d);
        ktlv_pkg::rsp_t r;
        r.found = d[0];
        r.model_out = d[16:1];
        r.slot = d[21:17];
        r.seen_out = d[37:22];
        r.pruned = d[43:38];
        return r;
    endfunction

    // Gap length: usually none or short, now and then long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Cycle counter and timeout.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d requests; %0d results checked.", sent, sb.checked);
            $display("keyed_table_lru_victim: mismatch");
            $finish;
        end
    end

    // Result side: sample at the rising edge, change m_tready at the falling edge.
    initial begin
        int g;
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            g = gap_len();
            if (g == 0) begin
                m_tready = 1;
                do @(posedge aclk); while (!m_tvalid);
                sb.check_result(unpack_result(m_tdata));
            end else begin
                m_tready = 0;
                repeat (g - 1) @(negedge aclk);
            end
        end
    end

    // Hands one request over and notes it when the handshake completes.
    task automatic send_request(ktlv_pkg::req_t r);
        int g;
        g = gap_len();
        repeat (g) @(negedge aclk);
        s_tdata = pack_request(r);
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
        sent++;
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    // Writes max_age_ms once every result is back and the block is quiet.
    task automatic write_max_age(bit [31:0] v);
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_wdata = v;
        cfg_wen = 1;
        @(negedge aclk);
        cfg_wen = 0;
        sb.max_age = v;
    endtask

    function automatic ktlv_pkg::req_t make_request(bit [2:0] c, bit [23:0] k);
        ktlv_pkg::req_t r;
        r.cmd = c;
        r.key = k;
        r.model_code = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
        r.callsign = ($urandom_range(0, 3) == 0) ? 64'h0 : {$urandom, $urandom};
        r.country_code = ($urandom_range(0, 3) == 0) ? 8'h0 : 8'($urandom);
        r.distance = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 32767));
        r.bearing = ($urandom_range(0, 3) == 0) ? 13'h1FFF : 13'($urandom_range(0, 3599));
        clock_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, 200000) : $urandom_range(0, 500);
        r.now_ms = clock_ms;
        r.active_value = $urandom_range(0, 1);
        return r;
    endfunction

    // Random phase: mostly adds and hits, some of each other code; key pool unless wide_keys.
    task automatic random_phase(int n, bit wide_keys);
        ktlv_pkg::req_t r;
        bit [23:0] k;
        int p;
        for (int i = 0; i < n; i++) begin
            k = (wide_keys || $urandom_range(0, 9) == 0) ? 24'($urandom) : keys[$urandom_range(0, 15)];
            p = $urandom_range(0, 99);
            if (p < 40)      r = make_request(ktlv_pkg::CMD_ADD, k);
            else if (p < 55) r = make_request(ktlv_pkg::CMD_LOOKUP, k);
            else if (p < 70) r = make_request(ktlv_pkg::CMD_TOUCH, k);
            else if (p < 77) r = make_request(ktlv_pkg::CMD_PRUNE, k);
            else if (p < 95) r = make_request(ktlv_pkg::CMD_SETACT, k);
            else             r = make_request(3'($urandom_range(5, 7)), k);
            send_request(r);
        end
    endtask

    initial begin
        ktlv_pkg::req_t r;
        sb = new();
        sent = 0;
        clock_ms = 32'd1000;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        cfg_wen = 0;
        cfg_wdata = '0;
        for (int i = 0; i < 16; i++) keys[i] = 24'($urandom);
        keys[0] = 24'h000000;
        keys[1] = 24'hFFFFFF;
        repeat (10) @(negedge aclk);
        aresetn = 1;

        // Directed: extreme fields, every command, misses on an empty table.
        r = make_request(ktlv_pkg::CMD_LOOKUP, 24'hFFFFFF); send_request(r);
        r = make_request(ktlv_pkg::CMD_TOUCH, 24'h0);       send_request(r);
        r = make_request(ktlv_pkg::CMD_SETACT, 24'h0);      send_request(r);
        r = '1; r.cmd = ktlv_pkg::CMD_ADD;                  send_request(r);
        r = '0; r.cmd = ktlv_pkg::CMD_ADD; r.distance = 16'h7FFF; r.bearing = 13'd3599;
        send_request(r);
        // A hit with empty fields must leave the stored values alone.
        r = '0; r.cmd = ktlv_pkg::CMD_ADD; r.key = 24'hFFFFFF; r.distance = 16'hFFFF;
        r.bearing = 13'h1FFF; r.now_ms = 32'hFFFFFFFF; send_request(r);
        r = '0; r.cmd = ktlv_pkg::CMD_LOOKUP; r.key = 24'hFFFFFF; send_request(r);
        r = '0; r.cmd = ktlv_pkg::CMD_SETACT; r.key = 24'hFFFFFF; r.active_value = 1;
        send_request(r);
        r = '0; r.cmd = ktlv_pkg::CMD_TOUCH; r.key = 24'h0; r.now_ms = 32'd5; send_request(r);
        r = '0; r.cmd = 3'd7; send_request(r);
        r = '0; r.cmd = 3'd5; r.key = 24'hFFFFFF; send_request(r);
        // Prune with wrapping age; both stored entries are past max_age and are pruned.
        r = '0; r.cmd = ktlv_pkg::CMD_PRUNE; r.now_ms = 32'h7FFFFFFF; send_request(r);

        write_max_age(32'd0);
        // Random requests with wide keys, aiming at victim choice and the ring pointer.
        random_phase(60, 1);
        // Every valid entry made active: with the table full, the ring slot becomes the victim.
        for (int i = 0; i < ktlv_pkg::DEPTH; i++)
            if (sb.valid[i]) begin
                r = make_request(ktlv_pkg::CMD_SETACT, sb.key_q[i]);
                r.active_value = 1;
                send_request(r);
            end
        random_phase(10, 1);
        write_max_age(32'hFFFFFFFF);
        random_phase(250, 0);
        write_max_age(32'd5000);
        random_phase(250, 0);
        write_max_age(32'd60000);
        random_phase(200, 1);

        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        $display("Sent %0d requests over four max_age settings; %0d results checked.",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("keyed_table_lru_victim: match");
        else
            $display("keyed_table_lru_victim: mismatch");
        $finish;
    end
endmodule
